/* hw/rtl/spwm_pkg.sv */
// Shared constants, types and register codes of the sine PWM duty generator.
package spwm_pkg;

   // Sine table geometry.
   localparam int TABLE_DEPTH  = 4096;
   localparam int TABLE_ADDR_W = $clog2(TABLE_DEPTH);
   // The phase counter must be able to hold TABLE_DEPTH itself.
   localparam int PHASE_W      = TABLE_ADDR_W + 1;

   // Field widths of the channels and registers.
   localparam int INDEX_W      = 12;
   localparam int SAMPLE_W     = 16;
   localparam int DUTY_W       = 16;
   localparam int PERIOD_W     = 16;
   localparam int SPC_W        = 13;
   localparam int AMP_W        = 8;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;

   // Register reset values.
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1000);
   localparam logic [SPC_W-1:0]    SPC_RESET    = SPC_W'(360);
   localparam logic [AMP_W-1:0]    AMP_RESET    = AMP_W'(90);

   // Scaled sample: signed sample times unsigned depth.
   localparam int PROD_W = SAMPLE_W + AMP_W + 1;
   // Floor division by 100 is done on a biased, non-negative value. The bias is
   // a multiple of 100 larger than the most negative product.
   localparam int BIAS_QUOT   = 84000;
   localparam int BIAS        = BIAS_QUOT * 100;
   localparam int BIASED_W    = 24;
   // Reciprocal of 100 scaled by 2^31; exact for every biased value below 2^24.
   localparam int RECIP_SHIFT = 31;
   localparam int RECIP_W     = 25;
   localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(21474837);
   localparam int QUOT_W      = 18;
   localparam int RPROD_W     = BIASED_W + RECIP_W;
   // Duty before clamping, signed.
   localparam int SUM_W       = 19;

   // Clamp floor.
   localparam int DUTY_MIN    = 2;

   typedef enum logic {
      MODE_TICK = 1'b0,
      MODE_LOAD = 1'b1
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TIMER_PERIOD      = 2'd0,
      CSR_SAMPLES_PER_CYCLE = 2'd1,
      CSR_AMPLITUDE_PERCENT = 2'd2
   } csr_index_type;

endpackage

/* hw/rtl/spwm_if.sv */
// Request and response channel interfaces of the sine PWM duty generator.
interface spwm_req_if;
   logic                                valid;
   logic                                ready;
   logic                                mode;
   logic [spwm_pkg::INDEX_W-1:0]        table_index;
   logic signed [spwm_pkg::SAMPLE_W-1:0] table_value;

   modport source (output valid, output mode, output table_index, output table_value,
                   input ready);
   modport sink   (input valid, input mode, input table_index, input table_value,
                   output ready);
endinterface

interface spwm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [spwm_pkg::DUTY_W-1:0]   duty;
   logic [spwm_pkg::INDEX_W-1:0]  phase_used;

   modport source (output valid, output duty, output phase_used, input ready);
   modport sink   (input valid, input duty, input phase_used, output ready);
endinterface

/* hw/rtl/sine_pwm_duty_generator.sv */
// Sine PWM duty generator: table load, phase counter and scaling pipeline.
//
// Load transfers write one signed entry of a 4096-entry sine table and return
// nothing. Each tick transfer reads the entry at the current phase (wrapped to
// zero once it reaches samples_per_cycle or the table depth), scales it by
// amplitude_percent/100 rounding toward minus infinity, adds half the PWM
// period, clamps the result to [2, period-2] and returns it with the phase
// it used. One transfer is taken every cycle unless the response is stalled;
// a tick's result is presented behind four registers: the registered table
// read, the depth multiply, the reciprocal multiply for the division by 100
// and the clamp stage. A stalled response holds the whole pipeline. Table
// entries read before they are written give an arbitrary duty. Registers
// may only be written while the block is idle.
module sine_pwm_duty_generator (
   input  logic                                clock,
   input  logic                                reset,
   spwm_req_if.sink                            req_chan,
   spwm_rsp_if.source                          rsp_chan,
   input  logic                                csr_write_enable,
   input  logic [spwm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [spwm_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   // Configuration registers.
   logic [spwm_pkg::PERIOD_W-1:0] period_ff, period_in;
   logic [spwm_pkg::SPC_W-1:0]    spc_ff, spc_in;
   logic [spwm_pkg::AMP_W-1:0]    amp_ff, amp_in;

   always_comb begin
      period_in = period_ff;
      spc_in    = spc_ff;
      amp_in    = amp_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            spwm_pkg::CSR_TIMER_PERIOD:      period_in = csr_write_data[spwm_pkg::PERIOD_W-1:0];
            spwm_pkg::CSR_SAMPLES_PER_CYCLE: spc_in    = csr_write_data[spwm_pkg::SPC_W-1:0];
            spwm_pkg::CSR_AMPLITUDE_PERCENT: amp_in    = csr_write_data[spwm_pkg::AMP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= spwm_pkg::PERIOD_RESET;
         spc_ff    <= spwm_pkg::SPC_RESET;
         amp_ff    <= spwm_pkg::AMP_RESET;
      end else begin
         period_ff <= period_in;
         spc_ff    <= spc_in;
         amp_ff    <= amp_in;
      end
   end

   // The whole pipeline advances together unless the response is stalled.
   logic advance;
   logic accept;
   logic is_tick;
   logic is_load;

   assign advance        = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = advance;
   assign accept         = req_chan.valid && advance;
   assign is_tick        = accept && (req_chan.mode == spwm_pkg::MODE_TICK);
   assign is_load        = accept && (req_chan.mode == spwm_pkg::MODE_LOAD);

   // Phase counter with wrap ahead of the lookup.
   logic [spwm_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [spwm_pkg::PHASE_W-1:0] phase_cur;

   always_comb begin
      if ((phase_ff >= spwm_pkg::PHASE_W'(spc_ff))
          || (phase_ff >= spwm_pkg::PHASE_W'(spwm_pkg::TABLE_DEPTH))) begin
         phase_cur = '0;
      end else begin
         phase_cur = phase_ff;
      end
      phase_in = phase_ff;
      if (is_tick) begin
         phase_in = phase_cur + spwm_pkg::PHASE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // Sine table: one write port for loads, one registered read port for ticks.
   logic [spwm_pkg::SAMPLE_W-1:0] table_mem [spwm_pkg::TABLE_DEPTH];
   logic [spwm_pkg::SAMPLE_W-1:0] sample_ff;
   logic                          load_in_range;

   assign load_in_range = {1'b0, req_chan.table_index}
                          < (spwm_pkg::INDEX_W+1)'(spwm_pkg::TABLE_DEPTH);

   always_ff @(posedge clock) begin
      if (is_load && load_in_range) begin
         table_mem[req_chan.table_index[spwm_pkg::TABLE_ADDR_W-1:0]] <= req_chan.table_value;
      end
      if (is_tick) begin
         sample_ff <= table_mem[phase_cur[spwm_pkg::TABLE_ADDR_W-1:0]];
      end
   end

   // Stage valids and carried phase.
   logic                          s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [spwm_pkg::INDEX_W-1:0]  s1_phase_ff, s2_phase_ff, s3_phase_ff;

   // Stage 1: scale by depth and bias to a non-negative value.
   logic signed [spwm_pkg::PROD_W-1:0] scaled;
   logic signed [spwm_pkg::PROD_W-1:0] biased;
   logic [spwm_pkg::BIASED_W-1:0]      biased_ff;

   assign scaled = spwm_pkg::PROD_W'($signed(sample_ff))
                   * spwm_pkg::PROD_W'($signed({1'b0, amp_ff}));
   assign biased = scaled + spwm_pkg::PROD_W'(spwm_pkg::BIAS);

   // Stage 2: divide by 100 through the reciprocal.
   logic [spwm_pkg::RPROD_W-1:0] recip_prod;
   logic [spwm_pkg::QUOT_W-1:0]  quot_ff;

   assign recip_prod = spwm_pkg::RPROD_W'(biased_ff) * spwm_pkg::RPROD_W'(spwm_pkg::RECIP_100);

   // Stage 3: remove the bias, add the midpoint and clamp.
   logic signed [spwm_pkg::SUM_W-1:0] sum_raw;
   logic signed [spwm_pkg::SUM_W-1:0] upper;
   logic signed [spwm_pkg::SUM_W-1:0] sum_clamped;

   always_comb begin
      sum_raw = $signed({1'b0, quot_ff})
                - spwm_pkg::SUM_W'(spwm_pkg::BIAS_QUOT)
                + $signed(spwm_pkg::SUM_W'(period_ff >> 1));
      upper   = $signed(spwm_pkg::SUM_W'(period_ff)) - spwm_pkg::SUM_W'(spwm_pkg::DUTY_MIN);
      sum_clamped = sum_raw;
      if (sum_clamped < spwm_pkg::SUM_W'(spwm_pkg::DUTY_MIN)) begin
         sum_clamped = spwm_pkg::SUM_W'(spwm_pkg::DUTY_MIN);
      end
      // With a very short period the upper limit wins over the lower one.
      if (sum_clamped > upper) begin
         sum_clamped = upper;
      end
   end

   // Response register.
   logic                          rsp_valid_ff;
   logic [spwm_pkg::DUTY_W-1:0]   duty_ff;
   logic [spwm_pkg::INDEX_W-1:0]  rsp_phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= is_tick;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_phase_ff  <= phase_cur[spwm_pkg::INDEX_W-1:0];
         s2_phase_ff  <= s1_phase_ff;
         s3_phase_ff  <= s2_phase_ff;
         rsp_phase_ff <= s3_phase_ff;
         biased_ff    <= biased[spwm_pkg::BIASED_W-1:0];
         quot_ff      <= recip_prod[spwm_pkg::RECIP_SHIFT +: spwm_pkg::QUOT_W];
         duty_ff      <= sum_clamped[spwm_pkg::DUTY_W-1:0];
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.duty       = duty_ff;
   assign rsp_chan.phase_used = rsp_phase_ff;

`ifndef SYNTH
   // The phase counter never runs beyond the table depth.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff <= spwm_pkg::PHASE_W'(spwm_pkg::TABLE_DEPTH))
      else $error("phase counter beyond table depth");

   // Requests are refused only while a response waits to be taken.
   assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (rsp_chan.valid && !rsp_chan.ready))
      else $error("request refused without a stalled response");

   // The reported phase lies inside the configured cycle.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (spc_ff != '0))
      |-> ({1'b0, rsp_chan.phase_used} < spc_ff))
      else $error("phase outside the configured cycle");

   // With a normal period the duty lies within the clamp limits.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (period_ff >= spwm_pkg::PERIOD_W'(4)))
      |-> ((rsp_chan.duty >= spwm_pkg::DUTY_W'(spwm_pkg::DUTY_MIN))
           && (rsp_chan.duty <= period_ff - spwm_pkg::PERIOD_W'(spwm_pkg::DUTY_MIN))))
      else $error("duty outside clamp limits");

   // A taken tick sets the first stage valid, so it is not lost on entry.
   assert property (@(posedge clock) disable iff (reset)
      is_tick |=> s1_valid_ff)
      else $error("accepted tick lost");
`endif

endmodule
